// ===== hdl/jgr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jgr_pkg: shared types and constants for the Jacobi grid relaxation block
// Request and result payloads, configuration register indexes, field widths.
// ----------------------------------------------------------------------------
package jgr_pkg;

  // default grid shape, ghost rows and columns included
  localparam int GRID_COLS_DEF = 12;
  localparam int GRID_ROWS_DEF = 5;

  // fixed field widths of the ports
  localparam int ROW_FW   = 3;
  localparam int COL_FW   = 4;
  localparam int VAL_W    = 32;
  localparam int SWEEP_W  = 16;
  localparam int SUM_W    = 64;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ROW  = 2'd0,
    CFG_LAST_ROW   = 2'd1,
    CFG_TOL_SQ     = 2'd2,
    CFG_MAX_SWEEPS = 2'd3
  } cfg_idx_t;

  // one loaded cell
  typedef struct packed {
    logic [ROW_FW-1:0]       cell_row;
    logic [COL_FW-1:0]       cell_col;
    logic signed [VAL_W-1:0] cell_value;
    logic                    last_cell;
  } jgr_in_t;

  // one emitted cell
  typedef struct packed {
    logic [ROW_FW-1:0]       out_row;
    logic [COL_FW-1:0]       out_col;
    logic signed [VAL_W-1:0] out_value;
    logic [SWEEP_W-1:0]      sweep_count;
    logic                    converged;
    logic                    last_out;
  } jgr_out_t;

endpackage
`default_nettype wire

// ===== hdl/jgr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jgr_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered. No reset on contents.
// ----------------------------------------------------------------------------
module jgr_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/jacobi_grid_relaxation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_grid_relaxation: five-point Jacobi relaxation of a small Q16.16 grid
// Loads cells, relaxes the interior rows until the squared change is small
// enough or a sweep limit is hit, then streams every cell out.
// ----------------------------------------------------------------------------
// Usage: load cells one per clock with start while busy is low. The request
// that carries last_cell (stored like any other, or dropped if its position
// is off the grid) kicks off relaxation and busy goes high. Each sweep runs
// the stencil work over all N interior cells, then a copy-back pass that
// reads and writes each of them when N > 0, then the stop check, where
// N = (hi - lo + 1) * (GRID_COLS - 2) interior cells. The stencil work is
// done one cell at a time because the grid store has a single read port
// (five reads: up, down, left, right, center), followed by the difference,
// the 32x32 squarer and the saturating Q32.32 accumulate of each cell, all
// sharing one datapath. Once the tolerance is met or max_sweeps sweeps are
// done, all GRID_ROWS*GRID_COLS cells are emitted in row-major order, one per
// cycle, each on out_valid for exactly one cycle; the receiver cannot stall,
// so it must take a cell every cycle it is offered. busy drops the cycle the
// last cell is shown. The grid memories are not cleared: reading a cell that
// was never loaded gives whatever the RAM holds. Configuration writes are
// taken at any time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module jacobi_grid_relaxation #(
  parameter int GRID_COLS = jgr_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = jgr_pkg::GRID_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // load request channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire jgr_pkg::jgr_in_t               in_data,
  // result channel
  output logic                                out_valid,
  output jgr_pkg::jgr_out_t                   out_data,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [jgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jgr_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CELLS   = GRID_ROWS * GRID_COLS;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int ROW_W   = $clog2(GRID_ROWS);
  localparam int COL_W   = $clog2(GRID_COLS);
  localparam int HI_MAX  = GRID_ROWS - 2;
  localparam int ROW_FW  = jgr_pkg::ROW_FW;
  localparam int COL_FW  = jgr_pkg::COL_FW;
  localparam int VAL_W   = jgr_pkg::VAL_W;
  localparam int SWEEP_W = jgr_pkg::SWEEP_W;
  localparam int SUM_W   = jgr_pkg::SUM_W;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 2);  // last interior col
  localparam logic [COL_W-1:0] COL_END  = COL_W'(GRID_COLS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELLS - 1);
  localparam logic [IDX_W-1:0] IDX_ROW  = IDX_W'(GRID_COLS);

  // stencil read sequence: reads 0..4 issued, data of read k-1 seen at step k
  localparam logic [2:0] STEP_UP     = 3'd0;
  localparam logic [2:0] STEP_DOWN   = 3'd1;
  localparam logic [2:0] STEP_LEFT   = 3'd2;
  localparam logic [2:0] STEP_RIGHT  = 3'd3;
  localparam logic [2:0] STEP_CENTER = 3'd4;
  localparam logic [2:0] STEP_DONE   = 3'd5;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_SW_INIT = 11'b000_0000_0010,
    S_SW_RD   = 11'b000_0000_0100,
    S_SW_DIFF = 11'b000_0000_1000,
    S_SW_MUL  = 11'b000_0001_0000,
    S_SW_ACC  = 11'b000_0010_0000,
    S_CP_INIT = 11'b000_0100_0000,
    S_CP_RD   = 11'b000_1000_0000,
    S_CP_WR   = 11'b001_0000_0000,
    S_CHECK   = 11'b010_0000_0000,
    S_EMIT    = 11'b100_0000_0000
  } state_t;

  // configuration registers
  logic [1:0]         first_row_r;
  logic [1:0]         last_row_r;
  logic [SUM_W-1:0]   tol_sq_r;
  logic [SWEEP_W-1:0] max_sweeps_r;

  // sequencer
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [2:0]         step_r, step_nxt;

  // shared datapath
  logic signed [VAL_W+1:0] acc_r, acc_nxt;     // four-neighbor sum
  logic [VAL_W-1:0]   ctr_r, ctr_nxt;          // old center value
  logic [VAL_W-1:0]   ad_r, ad_nxt;            // |new - old|
  logic [SUM_W-1:0]   sq_r, sq_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SWEEP_W-1:0] sweeps_r, sweeps_nxt;
  logic               conv_r, conv_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic [COL_W-1:0]   ocol_r, ocol_nxt;
  logic               olast_r, olast_nxt;

  // memory ports
  logic               g_we;
  logic [IDX_W-1:0]   g_waddr, g_raddr;
  logic [VAL_W-1:0]   g_wdata, g_rdata;
  logic               n_we;
  logic [VAL_W-1:0]   n_wdata, n_rdata;

  // misc combinational
  logic               in_acc, load_ok;
  logic [IDX_W-1:0]   load_idx, start_idx, nb_idx;
  logic [1:0]         lo_row;
  logic [31:0]        hi_row;
  logic               rows_empty, cell_last;
  logic [VAL_W-1:0]   new_val;
  logic [VAL_W:0]     diff;
  logic [SUM_W:0]     sum_ext;
  logic [SWEEP_W-1:0] sweeps_inc;
  logic               tol_met;

  assign busy   = (state_r != S_IDLE);
  assign in_acc = start && !busy;

  assign load_ok  = (32'(in_data.cell_row) < 32'(GRID_ROWS)) &&
                    (32'(in_data.cell_col) < 32'(GRID_COLS));
  assign load_idx = IDX_W'(32'(in_data.cell_row) * 32'(GRID_COLS) + 32'(in_data.cell_col));

  // relaxed row window: lo raised to 1, hi lowered to GRID_ROWS-2
  assign lo_row     = (first_row_r == 2'd0) ? 2'd1 : first_row_r;
  assign hi_row     = (32'(last_row_r) > 32'(HI_MAX)) ? 32'(HI_MAX) : 32'(last_row_r);
  assign rows_empty = 32'(lo_row) > hi_row;
  assign start_idx  = IDX_W'(32'(lo_row) * 32'(GRID_COLS) + 32'd1);
  assign cell_last  = (32'(row_r) == hi_row) && (col_r == COL_LAST);

  // stencil neighbor address
  always_comb begin
    unique case (step_r)
      STEP_UP:    nb_idx = idx_r - IDX_ROW;
      STEP_DOWN:  nb_idx = idx_r + IDX_ROW;
      STEP_LEFT:  nb_idx = idx_r - IDX_W'(1);
      STEP_RIGHT: nb_idx = idx_r + IDX_W'(1);
      default:    nb_idx = idx_r;
    endcase
  end

  // arithmetic shift by two on the 34-bit sum, then |new - old|
  assign new_val    = acc_r[VAL_W+1:2];
  assign diff       = {new_val[VAL_W-1], new_val} - {ctr_r[VAL_W-1], ctr_r};
  assign sum_ext    = {1'b0, sum_r} + {1'b0, sq_r};
  assign sweeps_inc = sweeps_r + SWEEP_W'(1);
  assign tol_met    = (sum_r <= tol_sq_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    ctr_nxt       = ctr_r;
    ad_nxt        = ad_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    sweeps_nxt    = sweeps_r;
    conv_nxt      = conv_r;
    out_valid_nxt = 1'b0;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    olast_nxt     = olast_r;
    g_we          = 1'b0;
    g_waddr       = idx_r;
    g_wdata       = n_rdata;
    g_raddr       = idx_r;
    n_we          = 1'b0;
    n_wdata       = new_val;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          g_we    = load_ok;
          g_waddr = load_idx;
          g_wdata = in_data.cell_value;
          if (in_data.last_cell) begin
            sweeps_nxt = '0;
            state_nxt  = S_SW_INIT;
          end
        end
      end

      S_SW_INIT: begin
        sum_nxt = '0;
        if (rows_empty) begin
          state_nxt = S_CHECK;
        end else begin
          idx_nxt   = start_idx;
          row_nxt   = ROW_W'(lo_row);
          col_nxt   = COL_W'(1);
          step_nxt  = STEP_UP;
          state_nxt = S_SW_RD;
        end
      end

      S_SW_RD: begin
        g_raddr  = nb_idx;
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_DOWN) begin
          acc_nxt = {{2{g_rdata[VAL_W-1]}}, g_rdata};
        end else if (step_r == STEP_LEFT || step_r == STEP_RIGHT ||
                     step_r == STEP_CENTER) begin
          acc_nxt = acc_r + {{2{g_rdata[VAL_W-1]}}, g_rdata};
        end else if (step_r == STEP_DONE) begin
          ctr_nxt   = g_rdata;
          state_nxt = S_SW_DIFF;
        end
      end

      S_SW_DIFF: begin
        n_we      = 1'b1;
        ad_nxt    = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
        state_nxt = S_SW_MUL;
      end

      S_SW_MUL: begin
        sq_nxt    = ad_r * ad_r;
        state_nxt = S_SW_ACC;
      end

      S_SW_ACC: begin
        sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];  // saturate
        if (cell_last) begin
          state_nxt = S_CP_INIT;
        end else begin
          if (col_r == COL_LAST) begin
            idx_nxt = idx_r + IDX_W'(3);
            row_nxt = row_r + ROW_W'(1);
            col_nxt = COL_W'(1);
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            col_nxt = col_r + COL_W'(1);
          end
          step_nxt  = STEP_UP;
          state_nxt = S_SW_RD;
        end
      end

      S_CP_INIT: begin
        idx_nxt   = start_idx;
        row_nxt   = ROW_W'(lo_row);
        col_nxt   = COL_W'(1);
        state_nxt = S_CP_RD;
      end

      S_CP_RD: begin
        state_nxt = S_CP_WR;
      end

      S_CP_WR: begin
        g_we = 1'b1;
        if (cell_last) begin
          state_nxt = S_CHECK;
        end else begin
          if (col_r == COL_LAST) begin
            idx_nxt = idx_r + IDX_W'(3);
            row_nxt = row_r + ROW_W'(1);
            col_nxt = COL_W'(1);
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            col_nxt = col_r + COL_W'(1);
          end
          state_nxt = S_CP_RD;
        end
      end

      S_CHECK: begin
        sweeps_nxt = sweeps_inc;
        if (tol_met || sweeps_inc >= max_sweeps_r) begin
          conv_nxt  = tol_met;
          idx_nxt   = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SW_INIT;
        end
      end

      S_EMIT: begin
        out_valid_nxt = 1'b1;
        orow_nxt      = row_r;
        ocol_nxt      = col_r;
        olast_nxt     = (idx_r == IDX_LAST);
        if (idx_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          if (col_r == COL_END) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_UP;
      sum_r       <= '0;
      sweeps_r    <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      sweeps_r    <= sweeps_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and counters, no reset
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    acc_r   <= acc_nxt;
    ctr_r   <= ctr_nxt;
    ad_r    <= ad_nxt;
    sq_r    <= sq_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r  <= 2'd1;
      last_row_r   <= 2'd3;
      tol_sq_r     <= '0;
      max_sweeps_r <= '1;
    end else if (cfg_we) begin
      unique case (jgr_pkg::cfg_idx_t'(cfg_index))
        jgr_pkg::CFG_FIRST_ROW:  first_row_r  <= cfg_wdata[1:0];
        jgr_pkg::CFG_LAST_ROW:   last_row_r   <= cfg_wdata[1:0];
        jgr_pkg::CFG_TOL_SQ:     tol_sq_r     <= cfg_wdata[SUM_W-1:0];
        jgr_pkg::CFG_MAX_SWEEPS: max_sweeps_r <= cfg_wdata[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // current grid
  jgr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // next grid, written by the stencil, read back by the copy pass
  jgr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_next (
    .clk   (clk),
    .we    (n_we),
    .waddr (idx_r),
    .wdata (n_wdata),
    .raddr (idx_r),
    .rdata (n_rdata)
  );

  // result: value comes straight from the grid read register
  assign out_valid = out_valid_r;
  always_comb begin
    out_data.out_row     = ROW_FW'(orow_r);
    out_data.out_col     = COL_FW'(ocol_r);
    out_data.out_value   = g_rdata;
    out_data.sweep_count = sweeps_r;
    out_data.converged   = conv_r;
    out_data.last_out    = olast_r;
  end

  // results only follow an emit cycle
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EMIT))
    else $error("result without emit");

  // relaxation only ends through the emit phase
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(state_r == S_EMIT))
    else $error("busy dropped outside emit");

  // the final cell closes the result stream
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data.last_out) |=> !out_valid_r)
    else $error("result after last cell");

  // not converged means the sweep limit was reached
  a_limit_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data.converged) |->
      (out_data.sweep_count >= max_sweeps_r && out_data.sweep_count != '0))
    else $error("gave up before sweep limit");

endmodule
`default_nettype wire
